FILE: design/owm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire bus master: register map,
// register reset values, command codes and fixed slot timing.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Register file geometry
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 16;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int DATA_W   = 32;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_W1_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_W1_REL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_W0_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_W0_REL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RD_REL  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RD_WIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_RST_LOW = 3'd6;
    localparam logic [IDX_W-1:0] REG_RST_REL = 3'd7;

    // Command codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Fixed timing
    localparam logic [REG_W-1:0] RESET_PRE_TICKS       = 16'd0;
    localparam logic [REG_W-1:0] PRESENCE_WINDOW_TICKS = 16'd410;

    // Slot timing as seen by the sequencer
    typedef struct packed {
        logic [REG_W-1:0] write_one_low_ticks;
        logic [REG_W-1:0] write_one_release_ticks;
        logic [REG_W-1:0] write_zero_low_ticks;
        logic [REG_W-1:0] write_zero_release_ticks;
        logic [REG_W-1:0] read_release_ticks;
        logic [REG_W-1:0] read_window_ticks;
        logic [REG_W-1:0] reset_low_ticks;
        logic [REG_W-1:0] reset_release_ticks;
    } t_cfg;

    // Reset value of each register
    function automatic logic [REG_W-1:0] reg_reset_value(input logic [IDX_W-1:0] idx);
        logic [REG_W-1:0] val;
        unique case (idx)
            REG_W1_LOW:  val = 16'd6;
            REG_W1_REL:  val = 16'd64;
            REG_W0_LOW:  val = 16'd60;
            REG_W0_REL:  val = 16'd10;
            REG_RD_REL:  val = 16'd9;
            REG_RD_WIN:  val = 16'd55;
            REG_RST_LOW: val = 16'd480;
            REG_RST_REL: val = 16'd70;
            default:     val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: design/owm_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_apb_regs
// APB register file holding the eight slot timing registers.
// ----------------------------------------------------------------------------
module owm_apb_regs
    import owm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [REG_W-1:0] r_regs [NUM_REGS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= reg_reset_value(IDX_W'(i));
            end
        end else if (wr_en) begin
            r_regs[idx] <= pwdata[REG_W-1:0];
        end
    end

    // Read back
    assign prdata = {{(DATA_W-REG_W){1'b0}}, r_regs[idx]};

    // Timing fields to the sequencer
    always_comb begin
        o_cfg.write_one_low_ticks      = r_regs[REG_W1_LOW];
        o_cfg.write_one_release_ticks  = r_regs[REG_W1_REL];
        o_cfg.write_zero_low_ticks     = r_regs[REG_W0_LOW];
        o_cfg.write_zero_release_ticks = r_regs[REG_W0_REL];
        o_cfg.read_release_ticks       = r_regs[REG_RD_REL];
        o_cfg.read_window_ticks        = r_regs[REG_RD_WIN];
        o_cfg.reset_low_ticks          = r_regs[REG_RST_LOW];
        o_cfg.reset_release_ticks      = r_regs[REG_RST_REL];
    end

endmodule
`default_nettype wire

FILE: design/onewire_bus_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_bus_master
// Tick-driven 1-Wire master: reset/presence, byte write and byte read.
// ----------------------------------------------------------------------------
// Each request is one bus tick carrying a command, a byte to send and the
// sampled line level; each request yields exactly one result with the line
// drive, busy and the sticky status flags after that tick. A request is
// taken every clock cycle while results drain; the sequencer state
// doubles as the result register, and a new request is accepted whenever
// that result is taken or none is pending. Commands are honored only while
// idle and clear all status flags. Slot timings come from eight 16-bit APB
// registers; they may be changed at any time and apply at once.
// ----------------------------------------------------------------------------
module onewire_bus_master
    import owm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_operation,
    input  wire logic [7:0]        i_send_byte,
    input  wire logic              i_bus_level,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_drive_low,
    output logic                   o_busy_res,
    output logic      [7:0]        o_received_byte,
    output logic                   o_sent_done,
    output logic                   o_received_done,
    output logic                   o_presence_seen,
    output logic                   o_fault,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // Sequencer phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_PRE = 4'd1;
    localparam logic [3:0] PH_RST_LOW = 4'd2;
    localparam logic [3:0] PH_RST_REL = 4'd3;
    localparam logic [3:0] PH_PRES    = 4'd4;
    localparam logic [3:0] PH_WR_INIT = 4'd5;
    localparam logic [3:0] PH_WR_LOW  = 4'd6;
    localparam logic [3:0] PH_WR_REL  = 4'd7;
    localparam logic [3:0] PH_WR_DONE = 4'd8;
    localparam logic [3:0] PH_RD_INIT = 4'd9;
    localparam logic [3:0] PH_RD_LOW  = 4'd10;
    localparam logic [3:0] PH_RD_REL  = 4'd11;
    localparam logic [3:0] PH_RD_WIN  = 4'd12;
    localparam logic [3:0] PH_RD_DONE = 4'd13;

    t_cfg cfg;

    logic [3:0]       r_phase,     n_phase;
    logic [REG_W-1:0] r_tick,      n_tick;
    logic [2:0]       r_bit_pos,   n_bit_pos;
    logic [7:0]       r_shift_out, n_shift_out;
    logic [7:0]       r_shift_in,  n_shift_in;
    logic             r_saw_low,   n_saw_low;
    logic             r_sent,      n_sent;
    logic             r_recv,      n_recv;
    logic             r_pres,      n_pres;
    logic             r_fault,     n_fault;
    logic             r_line,      n_line;
    logic             r_out_valid;

    logic             accept;
    logic             bus_low;
    logic             tx_bit;
    logic [REG_W-1:0] delay;
    logic [REG_W-1:0] elapsed;
    logic             timer_hit;

    owm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: state registers hold the result, so accept when it drains
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign bus_low = !i_bus_level;
    assign tx_bit  = r_shift_out[r_bit_pos];

    // Delay of the current timed phase
    always_comb begin
        unique case (r_phase)
            PH_RST_PRE: delay = RESET_PRE_TICKS;
            PH_RST_LOW: delay = cfg.reset_low_ticks;
            PH_RST_REL: delay = cfg.reset_release_ticks;
            PH_PRES:    delay = PRESENCE_WINDOW_TICKS;
            PH_WR_LOW:  delay = tx_bit ? cfg.write_one_low_ticks
                                       : cfg.write_zero_low_ticks;
            PH_WR_REL:  delay = tx_bit ? cfg.write_one_release_ticks
                                       : cfg.write_zero_release_ticks;
            PH_RD_LOW:  delay = cfg.write_one_low_ticks;
            PH_RD_REL:  delay = cfg.read_release_ticks;
            PH_RD_WIN:  delay = cfg.read_window_ticks;
            default:    delay = '0;
        endcase
    end

    // Saturating elapsed count and phase end
    assign elapsed   = (&r_tick) ? r_tick : r_tick + 16'd1;
    assign timer_hit = (elapsed >= delay);

    // Next state for one tick
    always_comb begin
        n_phase     = r_phase;
        n_tick      = '0;
        n_bit_pos   = r_bit_pos;
        n_shift_out = r_shift_out;
        n_shift_in  = r_shift_in;
        n_saw_low   = r_saw_low;
        n_sent      = r_sent;
        n_recv      = r_recv;
        n_pres      = r_pres;
        n_fault     = r_fault;
        n_line      = r_line;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_operation != OP_NONE) begin
                    n_sent    = 1'b0;
                    n_recv    = 1'b0;
                    n_pres    = 1'b0;
                    n_fault   = 1'b0;
                    n_line    = 1'b0;
                    n_bit_pos = '0;
                    n_saw_low = 1'b0;
                    case (i_operation)
                        OP_RESET: n_phase = PH_RST_PRE;
                        OP_WRITE: begin
                            n_shift_out = i_send_byte;
                            n_phase     = PH_WR_INIT;
                        end
                        default:  n_phase = PH_RD_INIT;
                    endcase
                end else begin
                    n_tick = r_tick;
                end
            end
            PH_RST_PRE: begin
                if (timer_hit) begin
                    n_phase = PH_RST_LOW;
                    n_line  = 1'b1;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_RST_LOW: begin
                if (timer_hit) begin
                    n_phase = PH_RST_REL;
                    n_line  = 1'b0;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_RST_REL: begin
                if (timer_hit) begin
                    n_phase = PH_PRES;
                    n_pres  = 1'b0;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_PRES: begin
                if (!timer_hit) begin
                    n_tick = elapsed;
                    if (bus_low) begin
                        n_pres = 1'b1;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    if (!r_pres) begin
                        n_fault = 1'b1;
                    end
                end
            end
            PH_WR_INIT: begin
                n_phase = PH_WR_LOW;
                n_line  = 1'b1;
            end
            PH_WR_LOW: begin
                if (timer_hit) begin
                    n_phase = PH_WR_REL;
                    n_line  = 1'b0;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_WR_REL: begin
                if (timer_hit) begin
                    n_phase = PH_WR_DONE;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_WR_DONE: begin
                if (&r_bit_pos) begin
                    n_bit_pos  = '0;
                    n_shift_in = '0;
                    n_sent     = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_bit_pos = r_bit_pos + 3'd1;
                    n_phase   = PH_WR_INIT;
                end
            end
            PH_RD_INIT: begin
                n_phase = PH_RD_LOW;
                n_line  = 1'b1;
            end
            PH_RD_LOW: begin
                if (timer_hit) begin
                    n_phase = PH_RD_REL;
                    n_line  = 1'b0;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_RD_REL: begin
                if (timer_hit) begin
                    n_phase = PH_RD_WIN;
                end else begin
                    n_tick = elapsed;
                end
            end
            PH_RD_WIN: begin
                if (!timer_hit) begin
                    n_tick = elapsed;
                    if (bus_low) begin
                        n_saw_low = 1'b1;
                    end
                end else begin
                    // bit reads 0 if the line was low anywhere in the window
                    n_shift_in[r_bit_pos] = !r_saw_low;
                    n_phase               = PH_RD_DONE;
                end
            end
            PH_RD_DONE: begin
                n_saw_low = 1'b0;
                if (&r_bit_pos) begin
                    n_bit_pos = '0;
                    n_recv    = 1'b1;
                    n_phase   = PH_IDLE;
                end else begin
                    n_bit_pos = r_bit_pos + 3'd1;
                    n_phase   = PH_RD_INIT;
                end
            end
            default: begin
                n_line  = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    // State / result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit_pos   <= '0;
            r_shift_out <= '0;
            r_shift_in  <= '0;
            r_saw_low   <= 1'b0;
            r_sent      <= 1'b0;
            r_recv      <= 1'b0;
            r_pres      <= 1'b0;
            r_fault     <= 1'b0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit_pos   <= n_bit_pos;
                r_shift_out <= n_shift_out;
                r_shift_in  <= n_shift_in;
                r_saw_low   <= n_saw_low;
                r_sent      <= n_sent;
                r_recv      <= n_recv;
                r_pres      <= n_pres;
                r_fault     <= n_fault;
                r_line      <= n_line;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields
    assign o_out_valid     = r_out_valid;
    assign o_drive_low     = r_line;
    assign o_busy_res      = (r_phase != PH_IDLE);
    assign o_received_byte = r_shift_in;
    assign o_sent_done     = r_sent;
    assign o_received_done = r_recv;
    assign o_presence_seen = r_pres;
    assign o_fault         = r_fault;

    // Checks
    a_fault_excl_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_fault && o_presence_seen))
        else $error("fault and presence both set");

    a_drive_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drive_low |-> o_busy_res)
        else $error("line driven low while idle");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_sent_done && o_received_done))
        else $error("write and read done both set");

    a_bitpos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bit_pos == 3'd0 && !r_saw_low))
        else $error("slot state left over in idle");

endmodule
`default_nettype wire
